// ===== rtl/fbsp_pkg.sv =====
`default_nettype none
package fbsp_pkg;
	localparam int MIN_FFT_LOG2 = 6;
	localparam int MAX_FFT_LOG2 = 14;
	localparam logic [14:0] FREQ_MIN = 15'd20;
	localparam logic [14:0] FREQ_MAX = 15'd20000;
	localparam logic [23:0] AMP_MAX = 24'hFFFFFF;
	localparam logic [31:0] AMP_SCALE = 32'd1273501707;
	localparam int AMP_SHIFT = 21;
	localparam logic [8:0] DEG_FULL = 9'd360;

	localparam logic [1:0] REG_RATE = 2'd0;
	localparam logic [1:0] REG_FFT_LOG2 = 2'd1;
	localparam logic [1:0] REG_START = 2'd2;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				5'd24: r = 32'd41;
				5'd25: r = 32'd20;
				5'd26: r = 32'd10;
				5'd27: r = 32'd5;
				5'd28: r = 32'd3;
				5'd29: r = 32'd1;
				5'd30: r = 32'd1;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	// front result handed to the back end
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic [31:0] ang;
		logic [14:0] freq;
		logic [12:0] bin;
		logic [31:0] start;
		logic [14:0] wlen;
	} front_word_t;
endpackage
`default_nettype wire

// ===== rtl/fbsp_front.sv =====
`default_nettype none
// bin range check, frequency, pre-rotation; two stages
module fbsp_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [13:0] bin_index,
	input  wire logic signed [31:0] real_part,
	input  wire logic signed [31:0] imag_part,
	input  wire logic [17:0] rate_hz,
	input  wire logic [3:0] fft_log2,
	input  wire logic [31:0] start_sample,
	output logic out_valid,
	output fbsp_pkg::front_word_t out_word
);
	logic [3:0] lg;
	logic in_rng;
	logic v_s1;
	logic [31:0] prod_s1;
	logic [3:0] lg_s1;
	logic [13:0] bin_s1;
	logic signed [33:0] x_s1, y_s1;
	logic neg_s1;
	logic [31:0] start_s1;
	logic [31:0] fr;

	always_comb begin
		lg = fft_log2;
		if (fft_log2 < 4'(fbsp_pkg::MIN_FFT_LOG2)) lg = 4'(fbsp_pkg::MIN_FFT_LOG2);
		if (fft_log2 > 4'(fbsp_pkg::MAX_FFT_LOG2)) lg = 4'(fbsp_pkg::MAX_FFT_LOG2);
		in_rng = (bin_index != 14'd0) && ({18'd0, bin_index} < (32'd1 << (lg - 4'd1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && in_rng;
			out_valid <= v_s1 && (fr >= 32'(fbsp_pkg::FREQ_MIN))
				&& (fr <= 32'(fbsp_pkg::FREQ_MAX));
		end
	end

	assign fr = prod_s1 >> lg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {18'd0, bin_index} * {14'd0, rate_hz};
			lg_s1 <= lg;
			bin_s1 <= bin_index;
			x_s1 <= 34'(real_part);
			y_s1 <= 34'(imag_part);
			neg_s1 <= real_part[31];
			start_s1 <= start_sample;
			out_word.x <= neg_s1 ? -x_s1 : x_s1;
			out_word.y <= neg_s1 ? -y_s1 : y_s1;
			out_word.ang <= neg_s1 ? 32'h8000_0000 : 32'd0;
			out_word.freq <= fr[14:0];
			out_word.bin <= bin_s1[12:0];
			out_word.start <= start_s1;
			out_word.wlen <= 15'(32'd1 << lg_s1);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fbsp_fifo.sv =====
`default_nettype none
// small queue between front and back
module fbsp_fifo #(
	parameter int W = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire logic [W-1:0] wdata,
	input  wire logic rd,
	output logic [W-1:0] rdata,
	output logic nonempty,
	output logic [2:0] count
);
	logic [W-1:0] mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end
	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wdata;
	assign rdata = mem_q[rp_q];
	assign count = cnt_q;
	assign nonempty = cnt_q != 3'd0;
endmodule
`default_nettype wire

// ===== rtl/fbsp_back.sv =====
`default_nettype none
// pipelined cordic, amplitude scale, phase to degrees
module fbsp_back #(
	parameter int FRACTION_BITS = 16,
	parameter int CORDIC_STAGES = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  fbsp_pkg::front_word_t in_word,
	output logic out_valid,
	output logic [14:0] frequency,
	output logic [23:0] amplitude,
	output logic [8:0] phase_degrees,
	output logic [12:0] bin_number,
	output logic [31:0] window_start,
	output logic [14:0] window_length
);
	localparam int N = CORDIC_STAGES;
	localparam int SH = FRACTION_BITS + fbsp_pkg::AMP_SHIFT;
	fbsp_pkg::front_word_t st [N+1];
	logic vld [N+1];
	assign st[0] = in_word;
	assign vld[0] = in_valid;

	for (genvar i = 0; i < N; i++) begin : g_st
		fbsp_pkg::front_word_t w_s;
		fbsp_pkg::front_word_t nxt;
		logic v_s;
		logic signed [33:0] xs, ys;
		assign xs = $signed(st[i].x) >>> i;
		assign ys = $signed(st[i].y) >>> i;
		always_comb begin
			nxt = st[i];
			if (!st[i].y[33]) begin
				nxt.x = st[i].x + ys;
				nxt.y = st[i].y - xs;
				nxt.ang = st[i].ang + fbsp_pkg::atan_lut(5'(i));
			end else begin
				nxt.x = st[i].x - ys;
				nxt.y = st[i].y + xs;
				nxt.ang = st[i].ang - fbsp_pkg::atan_lut(5'(i));
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s <= 1'b0;
			else if (en) v_s <= vld[i];
		end
		always_ff @(posedge clk) begin
			if (en) w_s <= nxt;
		end
		assign st[i+1] = w_s;
		assign vld[i+1] = v_s;
	end

	fbsp_pkg::front_word_t f_s1;
	logic v_s1, pos_s1;
	logic [65:0] amp_s1;
	logic [40:0] deg_s1;
	logic [65:0] a;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= vld[N];
			out_valid <= v_s1 && pos_s1 && (a != 66'd0);
		end
	end
	// x fits 34 bits; magnitude product and degree product
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= st[N];
			pos_s1 <= !st[N].x[33] && (st[N].x != 34'sd0);
			amp_s1 <= {32'd0, st[N].x[33:0]} * {34'd0, fbsp_pkg::AMP_SCALE};
			deg_s1 <= {9'd0, st[N].ang + 32'h8000_0000} * {32'd0, fbsp_pkg::DEG_FULL};
		end
	end
	assign a = amp_s1 >> SH;
	always_ff @(posedge clk) begin
		if (en) begin
			frequency <= f_s1.freq;
			amplitude <= (a > 66'(fbsp_pkg::AMP_MAX)) ? fbsp_pkg::AMP_MAX : a[23:0];
			phase_degrees <= deg_s1[40:32];
			bin_number <= f_s1.bin;
			window_start <= f_s1.start;
			window_length <= f_s1.wlen;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fft_bin_to_sinusoid_params.sv =====
`default_nettype none
// path: two front stages, one queue slot, the cordic stages and two back stages,
// the first front stage loaded at the accepting edge
// throughput: one word per cycle while the output is not held, set by the fully pipelined cordic
// back pipeline advances when its output is empty or taken; the front
// stops when the queue could not absorb its in-flight words
// reset: arst_n clears valid bits and pointers, registers go to 44100, 10, 0
module fft_bin_to_sinusoid_params #(
	parameter int FRACTION_BITS = 16,
	parameter int CORDIC_STAGES = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [79:0] s_tdata, // bin_index, real_part, imag_part
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [111:0] m_tdata, // frequency, amplitude, phase_degrees, bin_number,
	                              // window_start, window_length
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [17:0] rate_q;
	logic [3:0] lg_q;
	logic [31:0] start_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 18'd44100;
			lg_q <= 4'd10;
			start_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				fbsp_pkg::REG_RATE: rate_q <= pwdata[17:0];
				fbsp_pkg::REG_FFT_LOG2: lg_q <= pwdata[3:0];
				fbsp_pkg::REG_START: start_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			fbsp_pkg::REG_RATE: prdata = {14'd0, rate_q};
			fbsp_pkg::REG_FFT_LOG2: prdata = {28'd0, lg_q};
			fbsp_pkg::REG_START: prdata = start_q;
			default: prdata = '0;
		endcase
	end

	// front: free-running, gated by queue room (two words may be in flight)
	logic f_en, f_v;
	fbsp_pkg::front_word_t f_w;
	logic q_ne, q_rd, q_wr;
	logic [2:0] q_cnt;
	fbsp_pkg::front_word_t q_w;
	logic b_en;
	assign f_en = q_cnt <= 3'd1 || (q_cnt == 3'd2 && q_rd);
	assign s_tready = f_en;
	fbsp_front u_front (
		.clk, .arst_n, .en(f_en), .in_valid(s_tvalid),
		.bin_index(s_tdata[13:0]), .real_part(s_tdata[45:14]),
		.imag_part(s_tdata[77:46]), .rate_hz(rate_q), .fft_log2(lg_q),
		.start_sample(start_q), .out_valid(f_v), .out_word(f_w)
	);
	assign q_wr = f_en && f_v;

	// back pipeline stalls as a whole when its output is held
	assign b_en = !m_tvalid || m_tready;
	assign q_rd = b_en && q_ne;
	fbsp_fifo #(.W($bits(fbsp_pkg::front_word_t))) u_fifo (
		.clk, .arst_n, .wr(q_wr), .wdata(f_w), .rd(q_rd), .rdata(q_w),
		.nonempty(q_ne), .count(q_cnt)
	);
	fbsp_back #(.FRACTION_BITS(FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk, .arst_n, .en(b_en), .in_valid(q_rd), .in_word(q_w),
		.out_valid(m_tvalid), .frequency(m_tdata[14:0]), .amplitude(m_tdata[38:15]),
		.phase_degrees(m_tdata[47:39]), .bin_number(m_tdata[60:48]),
		.window_start(m_tdata[92:61]), .window_length(m_tdata[107:93])
	);
	assign m_tdata[111:108] = '0;

	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt <= 3'd4) else $error("queue overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_cnt != 3'd0) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== tb/sinusoid_checker.sv =====
`default_nettype none
module sinusoid_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic [111:0] m_tdata,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic pready,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [14:0] freq;
		logic [23:0] amp;
		logic [8:0] deg;
		logic [12:0] bin;
		logic [31:0] wstart;
		logic [14:0] wlen;
	} component_t;

	logic [17:0] rate_q;
	logic [3:0] log2_q;
	logic [31:0] start_q;
	component_t component_q[$];

	// bin and frequency range filters, then magnitude and phase by vectoring and the amplitude filter
	function automatic bit predict_component(input logic [79:0] w, output component_t c);
		int lg;
		longint unsigned bin, freq, amp, deg, ux;
		longint x, y, xs, ys;
		logic [31:0] ang, turned;
		lg = log2_q;
		bin = w[13:0];
		x = longint'($signed(w[45:14]));
		y = longint'($signed(w[77:46]));
		ang = '0;
		c = '0;
		if (lg < fbsp_pkg::MIN_FFT_LOG2) lg = fbsp_pkg::MIN_FFT_LOG2;
		if (lg > fbsp_pkg::MAX_FFT_LOG2) lg = fbsp_pkg::MAX_FFT_LOG2;
		if (bin < 1 || bin >= (64'd1 << (lg - 1))) return 0;
		freq = (bin * rate_q) >> lg;
		if (freq < fbsp_pkg::FREQ_MIN || freq > fbsp_pkg::FREQ_MAX) return 0;
		// left half plane: turn half a circle first
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 32'h8000_0000;
		end
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				ang = ang + fbsp_pkg::atan_lut(i[4:0]);
			end else begin
				x = x - ys;
				y = y + xs;
				ang = ang - fbsp_pkg::atan_lut(i[4:0]);
			end
		end
		if (x <= 0) return 0;
		ux = x;
		amp = (ux * fbsp_pkg::AMP_SCALE) >> (16 + fbsp_pkg::AMP_SHIFT);
		if (amp > fbsp_pkg::AMP_MAX) amp = fbsp_pkg::AMP_MAX;
		if (amp == 0) return 0;
		turned = ang + 32'h8000_0000;
		deg = ({32'd0, turned} * 64'd360) >> 32;
		c.freq = freq[14:0];
		c.amp = amp[23:0];
		c.deg = deg[8:0];
		c.bin = bin[12:0];
		c.wstart = start_q;
		c.wlen = 15'(1 << lg);
		return 1;
	endfunction

	function automatic void compare_field(input string name, input longint e, input longint a);
		if (e != a) begin
			$error("%s mismatch: expected %0d, got %0d", name, e, a);
			fail_count++;
		end
	endfunction

	assign pending = component_q.size();

	always @(posedge clk or negedge arst_n) begin
		component_t c, got;
		if (!arst_n) begin
			rate_q <= 18'd44100;
			log2_q <= 4'd10;
			start_q <= '0;
			component_q.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					fbsp_pkg::REG_RATE: rate_q <= pwdata[17:0];
					fbsp_pkg::REG_FFT_LOG2: log2_q <= pwdata[3:0];
					fbsp_pkg::REG_START: start_q <= pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready && predict_component(s_tdata, c))
				component_q.push_back(c);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[14:0], m_tdata[38:15], m_tdata[47:39], m_tdata[60:48],
					m_tdata[92:61], m_tdata[107:93]};
				if (component_q.size() == 0) begin
					$error("unexpected word from the block: %h", m_tdata);
					fail_count++;
				end else begin
					c = component_q.pop_front();
					compare_field("frequency", c.freq, got.freq);
					compare_field("amplitude", c.amp, got.amp);
					compare_field("phase_degrees", c.deg, got.deg);
					compare_field("bin_number", c.bin, got.bin);
					compare_field("window_start", c.wstart, got.wstart);
					compare_field("window_length", c.wlen, got.wlen);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0; // bin_index, real_part, imag_part
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [111:0] m_tdata; // frequency, amplitude, phase_degrees, bin_number,
	                       // window_start, window_length
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int tx_idle = 0;   // percent of words before which the sender holds back
	int rx_idle = 0;   // percent of cycles the receiver stalls
	int cur_log2 = 10; // fft size as the block will use it, after saturation
	longint cycles = 0;

	fft_bin_to_sinusoid_params dut (.*);

	sinusoid_checker checker_i (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// watchdog far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// apb write: setup cycle then access cycle, then idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// block drained, plus room for bins that give no word
	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(input logic [17:0] rate, input logic [3:0] lg, input logic [31:0] st);
		wait_idle();
		write_reg(fbsp_pkg::REG_RATE, {14'd0, rate});
		write_reg(fbsp_pkg::REG_FFT_LOG2, {28'd0, lg});
		write_reg(fbsp_pkg::REG_START, st);
		cur_log2 = (lg < fbsp_pkg::MIN_FFT_LOG2) ? fbsp_pkg::MIN_FFT_LOG2 :
			(lg > fbsp_pkg::MAX_FFT_LOG2) ? fbsp_pkg::MAX_FFT_LOG2 : int'(lg);
	endtask

	task automatic send_bin(input logic [13:0] bin, input logic [31:0] re, input logic [31:0] im);
		int gap;
		if ($urandom_range(0, 99) < tx_idle) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {2'b00, im, re, bin};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] random_part();
		logic [31:0] v;
		// spread magnitudes from huge down to below the amplitude floor
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic send_random();
		logic [13:0] bin;
		if ($urandom_range(0, 99) < 85)
			bin = 14'($urandom_range(1, (1 << (cur_log2 - 1)) - 1));
		else
			bin = 14'($urandom_range(0, 16383));
		send_bin(bin, random_part(), random_part());
	endtask

	initial begin
		logic [17:0] rate;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, 43 hz per bin
		tx_idle = 7;
		rx_idle = 60;
		send_bin(14'd0, 32'h0001_0000, 32'h0);          // dc bin
		send_bin(14'd1, 32'h0001_0000, 32'h0);          // first bin, phase 180
		send_bin(14'd465, 32'h0001_0000, 32'h0001_0000); // first bin above 20 khz
		send_bin(14'd466, 32'h0001_0000, 32'h0);        // above 20 khz
		send_bin(14'd511, 32'h0001_0000, 32'h0);        // top of half spectrum
		send_bin(14'd512, 32'h0001_0000, 32'h0);        // nyquist, rejected
		send_bin(14'd16383, 32'h7FFF_FFFF, 32'h0);
		send_bin(14'd10, 32'h0, 32'h0);                 // zero vector
		send_bin(14'd10, 32'h0000_0040, 32'h0);         // magnitude below floor
		send_bin(14'd10, 32'h8000_0000, 32'h8000_0000); // most negative parts
		send_bin(14'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // saturated amplitude
		send_bin(14'd10, 32'hFFFF_0000, 32'h0);         // negative real axis
		send_bin(14'd10, 32'h0, 32'hFFFF_0000);         // negative imaginary axis
		send_bin(14'd10, 32'h0, 32'h0001_0000);
		send_bin(14'd10, 32'hFFFF_0000, 32'hFFFF_FFFF);  // just below the branch cut
		s_tvalid <= 1'b0;

		// extremes of the registers
		configure(18'd0, 4'd0, 32'hFFFF_FFFF);  // zero rate, fft size floored
		send_bin(14'd5, 32'h0001_0000, 32'h0);
		send_bin(14'd31, 32'h0001_0000, 32'h0);
		s_tvalid <= 1'b0;
		configure(18'h3FFFF, 4'd15, 32'h0);      // fft size capped
		send_bin(14'd1, 32'h0001_0000, 32'h0);   // 15 hz, too low
		send_bin(14'd2, 32'h0001_0000, 32'h0);
		send_bin(14'd1250, 32'h0001_0000, 32'h0);
		send_bin(14'd8191, 32'h0001_0000, 32'h0);
		s_tvalid <= 1'b0;
		configure(18'd1, 4'd14, 32'h8000_0001);
		send_bin(14'd8191, 32'h0001_0000, 32'h0);
		s_tvalid <= 1'b0;

		// random phases, each with its own settings
		for (int n = 0; n < 550; n++) begin
			if (n % 50 == 0) begin
				s_tvalid <= 1'b0;
				case ($urandom_range(0, 4))
					0: rate = 18'd44100;
					1: rate = 18'd48000;
					2: rate = 18'd192000;
					3: rate = 18'd8000;
					default: rate = 18'($urandom_range(1, 262143));
				endcase
				configure(rate, 4'($urandom_range(0, 15)), $urandom);
				tx_idle = (n < 183) ? 7 : (n < 366) ? 60 : 0;
				rx_idle = (n < 183) ? 60 : (n < 366) ? 7 : 0;
			end
			// sender holds off until the block has emptied
			if (n == 275) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_random();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/fbsp_pkg.sv
rtl/fbsp_front.sv
rtl/fbsp_fifo.sv
rtl/fbsp_back.sv
rtl/fft_bin_to_sinusoid_params.sv
tb/sinusoid_checker.sv
tb/testbench.sv
